>>> rtl/vca_pkg.sv
// shared types and constants for the voice channel allocator
package vca_pkg;

	// default sizes
	localparam int NUM_CHANNELS_DEF  = 8;
	localparam int HANDLE_BITS_DEF   = 32;
	localparam int SOUND_ID_BITS_DEF = 16;

	// fixed field widths
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;
	localparam int ACTION_W = 3;
	localparam int FADE_W   = 16;
	localparam int SSTATE_W = 2;

	// command codes
	typedef enum logic [MODE_W-1:0] {
		MODE_PLAY     = 3'd0,
		MODE_STOP     = 3'd1,
		MODE_PAUSE    = 3'd2,
		MODE_RESUME   = 3'd3,
		MODE_QUERY    = 3'd4,
		MODE_STOP_ALL = 3'd5,
		MODE_FINISHED = 3'd6
	} mode_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 2'd0,
		ST_NOT_FOUND    = 2'd1,
		ST_ALREADY_PAUS = 2'd2,
		ST_ALREADY_PLAY = 2'd3
	} status_t;

	// mixer actions
	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE     = 3'd0,
		ACT_START    = 3'd1,
		ACT_FADE_IN  = 3'd2,
		ACT_HALT     = 3'd3,
		ACT_FADE_OUT = 3'd4,
		ACT_PAUSE    = 3'd5,
		ACT_RESUME   = 3'd6,
		ACT_HALT_ALL = 3'd7
	} action_t;

	// query answers
	typedef enum logic [SSTATE_W-1:0] {
		SS_STOPPED = 2'd0,
		SS_PAUSED  = 2'd1,
		SS_PLAYING = 2'd2
	} sstate_t;

	// update broadcast to the channel cells
	typedef enum logic [2:0] {
		WR_NONE     = 3'd0,
		WR_ALLOC    = 3'd1,
		WR_FREE     = 3'd2,
		WR_PAUSE    = 3'd3,
		WR_RESUME   = 3'd4,
		WR_FREE_ALL = 3'd5
	} wr_op_t;

	// search flags carried along the chain
	typedef struct packed {
		logic free;
		logic match;
		logic match_paused;
		logic same;
		logic nonloop;
		logic old;
	} scan_flags_t;

endpackage

>>> rtl/vca_cell.sv
// one channel cell: holds a voice entry and advances the search record by one step
module vca_cell
	import vca_pkg::*;
#(
	parameter int IDX           = 0,
	parameter int CW            = 3,
	parameter int HANDLE_BITS   = HANDLE_BITS_DEF,
	parameter int SOUND_ID_BITS = SOUND_ID_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// command under search
	input  logic [SOUND_ID_BITS-1:0] snd,
	input  logic [HANDLE_BITS-1:0]   target,
	// search record from the previous cell
	input  logic                     tok_in,
	input  scan_flags_t              flags_in,
	input  logic [CW-1:0]            free_idx_in,
	input  logic [CW-1:0]            match_idx_in,
	input  logic [CW-1:0]            same_idx_in,
	input  logic [HANDLE_BITS-1:0]   same_h_in,
	input  logic [CW-1:0]            nl_idx_in,
	input  logic [HANDLE_BITS-1:0]   nl_h_in,
	input  logic [CW-1:0]            old_idx_in,
	input  logic [HANDLE_BITS-1:0]   old_h_in,
	// search record to the next cell
	output logic                     tok_out,
	output scan_flags_t              flags_out,
	output logic [CW-1:0]            free_idx_out,
	output logic [CW-1:0]            match_idx_out,
	output logic [CW-1:0]            same_idx_out,
	output logic [HANDLE_BITS-1:0]   same_h_out,
	output logic [CW-1:0]            nl_idx_out,
	output logic [HANDLE_BITS-1:0]   nl_h_out,
	output logic [CW-1:0]            old_idx_out,
	output logic [HANDLE_BITS-1:0]   old_h_out,
	// entry update
	input  wr_op_t                   wr_op,
	input  logic [CW-1:0]            wr_chan,
	input  logic [HANDLE_BITS-1:0]   wr_handle,
	input  logic [SOUND_ID_BITS-1:0] wr_sound,
	input  logic                     wr_loop
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	// voice entry
	logic                     valid_q;
	logic [HANDLE_BITS-1:0]   handle_q;
	logic [SOUND_ID_BITS-1:0] sound_q;
	logic                     loop_q;
	logic                     paused_q;

	// search record stage
	logic                     tok_q;
	scan_flags_t              flags_q;
	logic [CW-1:0]            free_idx_q;
	logic [CW-1:0]            match_idx_q;
	logic [CW-1:0]            same_idx_q;
	logic [HANDLE_BITS-1:0]   same_h_q;
	logic [CW-1:0]            nl_idx_q;
	logic [HANDLE_BITS-1:0]   nl_h_q;
	logic [CW-1:0]            old_idx_q;
	logic [HANDLE_BITS-1:0]   old_h_q;

	scan_flags_t              f_nx;
	logic [CW-1:0]            free_idx_nx;
	logic [CW-1:0]            match_idx_nx;
	logic [CW-1:0]            same_idx_nx;
	logic [HANDLE_BITS-1:0]   same_h_nx;
	logic [CW-1:0]            nl_idx_nx;
	logic [HANDLE_BITS-1:0]   nl_h_nx;
	logic [CW-1:0]            old_idx_nx;
	logic [HANDLE_BITS-1:0]   old_h_nx;
	logic                     sel;

	assign sel = (wr_chan == MY_IDX);

	// fold this entry into the search record
	always_comb begin
		f_nx         = flags_in;
		free_idx_nx  = free_idx_in;
		match_idx_nx = match_idx_in;
		same_idx_nx  = same_idx_in;
		same_h_nx    = same_h_in;
		nl_idx_nx    = nl_idx_in;
		nl_h_nx      = nl_h_in;
		old_idx_nx   = old_idx_in;
		old_h_nx     = old_h_in;
		if (!flags_in.free && !valid_q) begin
			f_nx.free   = 1'b1;
			free_idx_nx = MY_IDX;
		end
		if (valid_q) begin
			if (!flags_in.match && handle_q == target) begin
				f_nx.match         = 1'b1;
				f_nx.match_paused  = paused_q;
				match_idx_nx       = MY_IDX;
			end
			if (sound_q == snd && (!flags_in.same || handle_q < same_h_in)) begin
				f_nx.same   = 1'b1;
				same_idx_nx = MY_IDX;
				same_h_nx   = handle_q;
			end
			if (!loop_q && (!flags_in.nonloop || handle_q < nl_h_in)) begin
				f_nx.nonloop = 1'b1;
				nl_idx_nx    = MY_IDX;
				nl_h_nx      = handle_q;
			end
			if (!flags_in.old || handle_q < old_h_in) begin
				f_nx.old   = 1'b1;
				old_idx_nx = MY_IDX;
				old_h_nx   = handle_q;
			end
		end
	end

	// token hand-off to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	// record hand-off to the next cell
	always_ff @(posedge clk) begin
		if (tok_in) begin
			flags_q     <= f_nx;
			free_idx_q  <= free_idx_nx;
			match_idx_q <= match_idx_nx;
			same_idx_q  <= same_idx_nx;
			same_h_q    <= same_h_nx;
			nl_idx_q    <= nl_idx_nx;
			nl_h_q      <= nl_h_nx;
			old_idx_q   <= old_idx_nx;
			old_h_q     <= old_h_nx;
		end
	end

	// entry occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (wr_op)
				WR_ALLOC: begin
					if (sel) valid_q <= 1'b1;
				end
				WR_FREE: begin
					if (sel) valid_q <= 1'b0;
				end
				WR_FREE_ALL: begin
					valid_q <= 1'b0;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	// entry contents
	always_ff @(posedge clk) begin
		unique case (wr_op)
			WR_ALLOC: begin
				if (sel) begin
					handle_q <= wr_handle;
					sound_q  <= wr_sound;
					loop_q   <= wr_loop;
					paused_q <= 1'b0;
				end
			end
			WR_PAUSE: begin
				if (sel) paused_q <= 1'b1;
			end
			WR_RESUME: begin
				if (sel) paused_q <= 1'b0;
			end
			default: begin
				paused_q <= paused_q;
			end
		endcase
	end

	assign tok_out       = tok_q;
	assign flags_out     = flags_q;
	assign free_idx_out  = free_idx_q;
	assign match_idx_out = match_idx_q;
	assign same_idx_out  = same_idx_q;
	assign same_h_out    = same_h_q;
	assign nl_idx_out    = nl_idx_q;
	assign nl_h_out      = nl_h_q;
	assign old_idx_out   = old_idx_q;
	assign old_h_out     = old_h_q;

endmodule

>>> rtl/voice_channel_allocator.sv
// Voice channel allocator: hands out mixer channels to play commands and tracks voices by
// handle. A command is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and it cannot be held off. Play, stop,
// pause, resume and query send a search record down the row of channel cells, one cell
// per cycle, and their result follows once the record has left the last cell; stop all,
// channel finished and the unused code need no search. The result is shown in the first
// cycle with busy low, and the next start can be taken at the edge that ends that cycle.
module voice_channel_allocator
	import vca_pkg::*;
#(
	parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
	parameter int HANDLE_BITS   = HANDLE_BITS_DEF,
	parameter int SOUND_ID_BITS = SOUND_ID_BITS_DEF,
	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// command transaction
	input  logic                     start,
	output logic                     busy,
	input  logic [MODE_W-1:0]        mode,
	input  logic [SOUND_ID_BITS-1:0] sound_id,
	input  logic                     looping,
	input  logic [FADE_W-1:0]        fade_ms,
	input  logic [HANDLE_BITS-1:0]   target_handle,
	input  logic [CW-1:0]            finished_channel,
	// result transaction
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [HANDLE_BITS-1:0]   new_handle,
	output logic [CW-1:0]            chan,
	output logic                     stolen,
	output logic [ACTION_W-1:0]      action,
	output logic                     loop_forever,
	output logic [FADE_W-1:0]        fade_out_ms,
	output logic [SSTATE_W-1:0]      sound_state
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_APPLY = 3'b100
	} fsm_t;

	fsm_t state_q;
	logic launch_q;
	logic [HANDLE_BITS-1:0] cnt_q;

	// latched command
	mode_t                    mode_q;
	logic [SOUND_ID_BITS-1:0] snd_q;
	logic                     loop_q;
	logic [FADE_W-1:0]        fade_q;
	logic [HANDLE_BITS-1:0]   target_q;
	logic [CW-1:0]            fin_q;

	// links between cells
	logic                   tok_l      [NUM_CHANNELS+1];
	scan_flags_t            flags_l    [NUM_CHANNELS+1];
	logic [CW-1:0]          free_idx_l [NUM_CHANNELS+1];
	logic [CW-1:0]          match_idx_l[NUM_CHANNELS+1];
	logic [CW-1:0]          same_idx_l [NUM_CHANNELS+1];
	logic [HANDLE_BITS-1:0] same_h_l   [NUM_CHANNELS+1];
	logic [CW-1:0]          nl_idx_l   [NUM_CHANNELS+1];
	logic [HANDLE_BITS-1:0] nl_h_l     [NUM_CHANNELS+1];
	logic [CW-1:0]          old_idx_l  [NUM_CHANNELS+1];
	logic [HANDLE_BITS-1:0] old_h_l    [NUM_CHANNELS+1];

	// update and result of the command being finished
	wr_op_t                 wr_op;
	logic [CW-1:0]          wr_chan;
	logic [HANDLE_BITS-1:0] cnt_nx;
	logic                   apply;
	logic                   accept;
	logic                   needs_scan;
	scan_flags_t            fe;
	status_t                status_nx;
	logic [HANDLE_BITS-1:0] handle_nx;
	logic [CW-1:0]          chan_nx;
	logic                   stolen_nx;
	action_t                action_nx;
	logic                   loop_nx;
	logic [FADE_W-1:0]      fade_nx;
	sstate_t                sstate_nx;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign needs_scan = (mode_t'(mode) == MODE_PLAY) || (mode_t'(mode) == MODE_STOP) ||
		(mode_t'(mode) == MODE_PAUSE) || (mode_t'(mode) == MODE_RESUME) ||
		(mode_t'(mode) == MODE_QUERY);
	assign apply  = ((state_q == S_SCAN) && tok_l[NUM_CHANNELS]) || (state_q == S_APPLY);

	// empty search record enters the first cell
	assign tok_l[0]       = launch_q;
	assign flags_l[0]     = '0;
	assign free_idx_l[0]  = '0;
	assign match_idx_l[0] = '0;
	assign same_idx_l[0]  = '0;
	assign same_h_l[0]    = '0;
	assign nl_idx_l[0]    = '0;
	assign nl_h_l[0]      = '0;
	assign old_idx_l[0]   = '0;
	assign old_h_l[0]     = '0;

	// row of channel cells
	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
		vca_cell #(
			.IDX(i),
			.CW(CW),
			.HANDLE_BITS(HANDLE_BITS),
			.SOUND_ID_BITS(SOUND_ID_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.snd(snd_q),
			.target(target_q),
			.tok_in(tok_l[i]),
			.flags_in(flags_l[i]),
			.free_idx_in(free_idx_l[i]),
			.match_idx_in(match_idx_l[i]),
			.same_idx_in(same_idx_l[i]),
			.same_h_in(same_h_l[i]),
			.nl_idx_in(nl_idx_l[i]),
			.nl_h_in(nl_h_l[i]),
			.old_idx_in(old_idx_l[i]),
			.old_h_in(old_h_l[i]),
			.tok_out(tok_l[i+1]),
			.flags_out(flags_l[i+1]),
			.free_idx_out(free_idx_l[i+1]),
			.match_idx_out(match_idx_l[i+1]),
			.same_idx_out(same_idx_l[i+1]),
			.same_h_out(same_h_l[i+1]),
			.nl_idx_out(nl_idx_l[i+1]),
			.nl_h_out(nl_h_l[i+1]),
			.old_idx_out(old_idx_l[i+1]),
			.old_h_out(old_h_l[i+1]),
			.wr_op(wr_op),
			.wr_chan(wr_chan),
			.wr_handle(cnt_nx),
			.wr_sound(snd_q),
			.wr_loop(loop_q)
		);
	end

	// next handle, zero skipped on wrap
	always_comb begin
		cnt_nx = cnt_q + HANDLE_BITS'(1);
		if (cnt_nx == '0) cnt_nx = HANDLE_BITS'(1);
	end

	// decide the result and the entry update from the finished search
	always_comb begin
		fe        = flags_l[NUM_CHANNELS];
		wr_op     = WR_NONE;
		wr_chan   = '0;
		status_nx = ST_OK;
		handle_nx = '0;
		chan_nx   = '0;
		stolen_nx = 1'b0;
		action_nx = ACT_NONE;
		loop_nx   = 1'b0;
		fade_nx   = '0;
		sstate_nx = SS_STOPPED;
		unique case (mode_q)
			MODE_PLAY: begin
				priority if (fe.free) chan_nx = free_idx_l[NUM_CHANNELS];
				else if (fe.same)    chan_nx = same_idx_l[NUM_CHANNELS];
				else if (fe.nonloop) chan_nx = nl_idx_l[NUM_CHANNELS];
				else                 chan_nx = old_idx_l[NUM_CHANNELS];
				stolen_nx = !fe.free;
				handle_nx = cnt_nx;
				loop_nx   = loop_q;
				wr_op     = WR_ALLOC;
				wr_chan   = chan_nx;
				if (fade_q != '0) begin
					action_nx = ACT_FADE_IN;
					fade_nx   = fade_q;
				end else begin
					action_nx = ACT_START;
				end
			end
			MODE_STOP: begin
				if (!fe.match) begin
					status_nx = ST_NOT_FOUND;
				end else begin
					chan_nx = match_idx_l[NUM_CHANNELS];
					if (fade_q != '0) begin
						action_nx = ACT_FADE_OUT;
						fade_nx   = fade_q;
					end else begin
						action_nx = ACT_HALT;
						wr_op     = WR_FREE;
						wr_chan   = chan_nx;
					end
				end
			end
			MODE_PAUSE: begin
				priority if (!fe.match) begin
					status_nx = ST_NOT_FOUND;
				end else if (fe.match_paused) begin
					status_nx = ST_ALREADY_PAUS;
				end else begin
					chan_nx   = match_idx_l[NUM_CHANNELS];
					action_nx = ACT_PAUSE;
					wr_op     = WR_PAUSE;
					wr_chan   = chan_nx;
				end
			end
			MODE_RESUME: begin
				priority if (!fe.match) begin
					status_nx = ST_NOT_FOUND;
				end else if (!fe.match_paused) begin
					status_nx = ST_ALREADY_PLAY;
				end else begin
					chan_nx   = match_idx_l[NUM_CHANNELS];
					action_nx = ACT_RESUME;
					wr_op     = WR_RESUME;
					wr_chan   = chan_nx;
				end
			end
			MODE_QUERY: begin
				if (fe.match) sstate_nx = fe.match_paused ? SS_PAUSED : SS_PLAYING;
			end
			MODE_STOP_ALL: begin
				action_nx = ACT_HALT_ALL;
				wr_op     = WR_FREE_ALL;
			end
			MODE_FINISHED: begin
				if (int'(fin_q) < NUM_CHANNELS) begin
					wr_op   = WR_FREE;
					wr_chan = fin_q;
				end
			end
			default: begin
				wr_op = WR_NONE;
			end
		endcase
		if (!apply) wr_op = WR_NONE;
	end

	// sequencing, handle counter and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
			cnt_q    <= '0;
			done     <= 1'b0;
		end else begin
			launch_q <= accept && needs_scan;
			done     <= apply;
			if (apply && mode_q == MODE_PLAY) cnt_q <= cnt_nx;
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= needs_scan ? S_SCAN : S_APPLY;
				end
				S_SCAN: begin
					if (tok_l[NUM_CHANNELS]) state_q <= S_IDLE;
				end
				S_APPLY: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode_t'(mode);
			snd_q    <= sound_id;
			loop_q   <= looping;
			fade_q   <= fade_ms;
			target_q <= target_handle;
			fin_q    <= finished_channel;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (apply) begin
			status       <= status_nx;
			new_handle   <= handle_nx;
			chan         <= chan_nx;
			stolen       <= stolen_nx;
			action       <= action_nx;
			loop_forever <= loop_nx;
			fade_out_ms  <= fade_nx;
			sound_state  <= sstate_nx;
		end
	end

endmodule

>>> sim/tb_voice_channel_allocator.sv
// testbench for the voice channel allocator: directed and random commands checked against a voice model
`timescale 1ns / 100ps

module tb_voice_channel_allocator;
	import vca_pkg::*;

	localparam int NCH = NUM_CHANNELS_DEF;
	localparam int HB  = HANDLE_BITS_DEF;
	localparam int SB  = SOUND_ID_BITS_DEF;
	localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;

	// command code that the block ignores
	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

	localparam int RANDOM_ITEMS = 1375;
	localparam int STALL_LIMIT  = 2000;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		status_t             status;
		logic [HB-1:0]       new_handle;
		logic [CW-1:0]       chan;
		logic                stolen;
		action_t             action;
		logic                loop_forever;
		logic [FADE_W-1:0]   fade_out_ms;
		sstate_t             sound_state;
	} mixer_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [MODE_W-1:0]   mode = '0;
	logic [SB-1:0]       sound_id = '0;
	logic                looping = 1'b0;
	logic [FADE_W-1:0]   fade_ms = '0;
	logic [HB-1:0]       target_handle = '0;
	logic [CW-1:0]       finished_channel = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [HB-1:0]       new_handle;
	logic [CW-1:0]       chan;
	logic                stolen;
	logic [ACTION_W-1:0] action;
	logic                loop_forever;
	logic [FADE_W-1:0]   fade_out_ms;
	logic [SSTATE_W-1:0] sound_state;

	// voice table as the testbench sees it
	bit            voice_live[NCH];
	logic [HB-1:0] voice_handle[NCH];
	logic [SB-1:0] voice_sound[NCH];
	bit            voice_loops[NCH];
	bit            voice_paused[NCH];
	logic [HB-1:0] last_handle = '0;

	mixer_reply_t pending_replies[$];
	int           error_count = 0;
	int           quiet_cycles = 0;
	bit           idle_off = 1'b0;

	voice_channel_allocator i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.mode             (mode),
		.sound_id         (sound_id),
		.looping          (looping),
		.fade_ms          (fade_ms),
		.target_handle    (target_handle),
		.finished_channel (finished_channel),
		.done             (done),
		.status           (status),
		.new_handle       (new_handle),
		.chan             (chan),
		.stolen           (stolen),
		.action           (action),
		.loop_forever     (loop_forever),
		.fade_out_ms      (fade_out_ms),
		.sound_state      (sound_state)
	);

	always #5 clk = ~clk;

	// lowest live channel holding the handle, NCH if none
	function automatic int find_voice(input logic [HB-1:0] h);
		int i;
		for (i = 0; i < NCH; i++)
			if (voice_live[i] && voice_handle[i] == h)
				return i;
		return NCH;
	endfunction

	// oldest voice of the same sound, else oldest non-looping, else oldest
	function automatic int steal_victim(input logic [SB-1:0] snd);
		int i, same, nonloop, oldest;
		same = NCH;
		nonloop = NCH;
		oldest = NCH;
		for (i = 0; i < NCH; i++) begin
			if (voice_live[i]) begin
				if (voice_sound[i] == snd &&
				    (same == NCH || voice_handle[i] < voice_handle[same]))
					same = i;
				if (!voice_loops[i] &&
				    (nonloop == NCH || voice_handle[i] < voice_handle[nonloop]))
					nonloop = i;
				if (oldest == NCH || voice_handle[i] < voice_handle[oldest])
					oldest = i;
			end
		end
		if (same != NCH)
			return same;
		if (nonloop != NCH)
			return nonloop;
		return oldest;
	endfunction

	// mixer reply for one command, updating the voice table
	function automatic mixer_reply_t compute_mixer_reply(input logic [MODE_W-1:0] m,
		input logic [SB-1:0] snd, input logic lp, input logic [FADE_W-1:0] fade,
		input logic [HB-1:0] target, input logic [CW-1:0] fin);
		mixer_reply_t r;
		int ch, i;
		r = '0;
		case (m)
			MODE_PLAY: begin
				ch = NCH;
				for (i = NCH - 1; i >= 0; i--)
					if (!voice_live[i])
						ch = i;
				if (ch == NCH) begin
					ch = steal_victim(snd);
					r.stolen = 1'b1;
				end
				// handle zero is never issued
				last_handle = last_handle + 1'b1;
				if (last_handle == '0)
					last_handle = HB'(1);
				voice_live[ch] = 1'b1;
				voice_handle[ch] = last_handle;
				voice_sound[ch] = snd;
				voice_loops[ch] = lp;
				voice_paused[ch] = 1'b0;
				r.new_handle = last_handle;
				r.chan = ch[CW-1:0];
				r.loop_forever = lp;
				if (fade != '0) begin
					r.action = ACT_FADE_IN;
					r.fade_out_ms = fade;
				end else begin
					r.action = ACT_START;
				end
			end
			MODE_STOP: begin
				ch = find_voice(target);
				if (ch == NCH) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.chan = ch[CW-1:0];
					// a fading voice keeps its channel until the mixer reports it
					if (fade != '0) begin
						r.action = ACT_FADE_OUT;
						r.fade_out_ms = fade;
					end else begin
						r.action = ACT_HALT;
						voice_live[ch] = 1'b0;
					end
				end
			end
			MODE_PAUSE, MODE_RESUME: begin
				ch = find_voice(target);
				if (ch == NCH)
					r.status = ST_NOT_FOUND;
				else if (m == MODE_PAUSE && voice_paused[ch])
					r.status = ST_ALREADY_PAUS;
				else if (m == MODE_RESUME && !voice_paused[ch])
					r.status = ST_ALREADY_PLAY;
				else begin
					voice_paused[ch] = (m == MODE_PAUSE);
					r.chan = ch[CW-1:0];
					r.action = (m == MODE_PAUSE) ? ACT_PAUSE : ACT_RESUME;
				end
			end
			MODE_QUERY: begin
				ch = find_voice(target);
				if (ch != NCH)
					r.sound_state = voice_paused[ch] ? SS_PAUSED : SS_PLAYING;
			end
			MODE_STOP_ALL: begin
				for (i = 0; i < NCH; i++)
					voice_live[i] = 1'b0;
				r.action = ACT_HALT_ALL;
			end
			MODE_FINISHED: begin
				if (fin < NCH)
					voice_live[fin] = 1'b0;
			end
			// unused code: no change, all-zero reply
			default: ;
		endcase
		return r;
	endfunction

	// one command transaction, with random gaps ahead of it
	task automatic send_command(input logic [MODE_W-1:0] m, input logic [SB-1:0] snd,
		input logic lp, input logic [FADE_W-1:0] fade, input logic [HB-1:0] target,
		input logic [CW-1:0] fin);
		while (!idle_off && $urandom_range(99) < 19) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		sound_id <= snd;
		looping <= lp;
		fade_ms <= fade;
		target_handle <= target;
		finished_channel <= fin;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_replies.push_back(compute_mixer_reply(m, snd, lp, fade, target, fin));
	endtask

	task automatic test_unused_code;
		send_command(MODE_UNUSED, '1, 1'b1, '1, '1, '1);
	endtask

	// fill every channel, then each of the three steal rules
	task automatic test_fill_and_steal;
		int k;
		send_command(MODE_PLAY, '1, 1'b1, '1, '1, '1);
		send_command(MODE_PLAY, '0, 1'b0, '0, '0, '0);
		send_command(MODE_PLAY, 16'd3, 1'b1, '0, '0, '0);
		send_command(MODE_PLAY, 16'd3, 1'b0, '0, '0, '0);
		for (k = 0; k < NCH - 4; k++)
			send_command(MODE_PLAY, 16'd5, 1'b1, 16'd1, '0, '0);
		// same sound
		send_command(MODE_PLAY, 16'd3, 1'b1, '0, '0, '0);
		// oldest non-looping
		send_command(MODE_PLAY, 16'd9, 1'b1, '0, '0, '0);
		// free the last non-looping voice and refill with a looping one
		send_command(MODE_STOP, '0, 1'b0, '0, 32'd4, '0);
		send_command(MODE_PLAY, 16'd7, 1'b1, '0, '0, '0);
		// every voice loops: the oldest goes
		send_command(MODE_PLAY, 16'd100, 1'b1, '0, '0, '0);
	endtask

	// fade-out stop holds the channel until the finished event
	task automatic test_fade_stop_and_finish;
		send_command(MODE_STOP, '0, 1'b0, '1, 32'd5, '0);
		send_command(MODE_QUERY, '0, 1'b0, '0, 32'd5, '0);
		send_command(MODE_FINISHED, '0, 1'b0, '0, '0, 3'd4);
		send_command(MODE_FINISHED, '0, 1'b0, '0, '0, 3'd4);
		send_command(MODE_QUERY, '0, 1'b0, '0, 32'd5, '0);
	endtask

	task automatic test_pause_resume;
		send_command(MODE_PAUSE, '0, 1'b0, '0, 32'd6, '0);
		send_command(MODE_PAUSE, '0, 1'b0, '0, 32'd6, '0);
		send_command(MODE_QUERY, '0, 1'b0, '0, 32'd6, '0);
		send_command(MODE_RESUME, '0, 1'b0, '0, 32'd6, '0);
		send_command(MODE_RESUME, '0, 1'b0, '0, 32'd6, '0);
	endtask

	task automatic test_missing_and_stop_all;
		send_command(MODE_STOP, '0, 1'b0, '0, '0, '0);
		send_command(MODE_PAUSE, '0, 1'b0, '0, '1, '0);
		send_command(MODE_STOP_ALL, '1, 1'b1, '1, '1, '1);
	endtask

	// mostly commands aimed at live voices, the rest random handles
	task automatic test_random_traffic(input int n);
		int k, pick, j;
		logic [MODE_W-1:0] m;
		logic [SB-1:0] snd;
		logic [FADE_W-1:0] fade;
		logic [HB-1:0] target;
		logic [CW-1:0] fin;
		for (k = 0; k < n; k++) begin
			// a long stretch with the sender never pausing
			idle_off = (k >= 400 && k < 700);
			pick = $urandom_range(99);
			if (pick < 36)
				m = MODE_PLAY;
			else if (pick < 48)
				m = MODE_STOP;
			else if (pick < 58)
				m = MODE_PAUSE;
			else if (pick < 68)
				m = MODE_RESUME;
			else if (pick < 78)
				m = MODE_QUERY;
			else if (pick < 93)
				m = MODE_FINISHED;
			else if (pick < 96)
				m = MODE_STOP_ALL;
			else
				m = MODE_UNUSED;
			// a small pool of sounds so that same-sound steals happen
			snd = ($urandom_range(3) != 0) ? SB'($urandom_range(7)) : SB'($urandom);
			pick = $urandom_range(3);
			if (pick < 2)
				fade = '0;
			else if (pick == 2)
				fade = FADE_W'($urandom_range(1, 100));
			else
				fade = FADE_W'($urandom);
			pick = $urandom_range(99);
			j = $urandom_range(NCH - 1);
			if (pick < 65 && voice_live[j])
				target = voice_handle[j];
			else if (pick < 80)
				target = last_handle - HB'($urandom_range(3));
			else
				target = HB'($urandom);
			fin = ($urandom_range(9) < 7 && voice_live[j]) ? CW'(j) : CW'($urandom);
			send_command(m, snd, 1'($urandom), fade, target, fin);
		end
		idle_off = 1'b0;
	endtask

	// result check against the oldest pending reply
	always @(posedge clk) begin
		mixer_reply_t got, want;
		if (arst_n && done) begin
			got.status = status_t'(status);
			got.new_handle = new_handle;
			got.chan = chan;
			got.stolen = stolen;
			got.action = action_t'(action);
			got.loop_forever = loop_forever;
			got.fade_out_ms = fade_out_ms;
			got.sound_state = sstate_t'(sound_state);
			if (pending_replies.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: result with none pending: act=%0d ch=%0d h=%0h",
						$realtime, got.action, got.chan, got.new_handle);
			end else begin
				want = pending_replies.pop_front();
				if (got.status !== want.status || got.new_handle !== want.new_handle ||
				    got.chan !== want.chan || got.stolen !== want.stolen ||
				    got.action !== want.action || got.loop_forever !== want.loop_forever ||
				    got.fade_out_ms !== want.fade_out_ms ||
				    got.sound_state !== want.sound_state) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("%0t: mismatch", $realtime);
						$display("  expected st=%0d h=%0h ch=%0d stl=%0b act=%0d lp=%0b fade=%0h ss=%0d",
							want.status, want.new_handle, want.chan, want.stolen,
							want.action, want.loop_forever, want.fade_out_ms,
							want.sound_state);
						$display("  actual   st=%0d h=%0h ch=%0d stl=%0b act=%0d lp=%0b fade=%0h ss=%0d",
							got.status, got.new_handle, got.chan, got.stolen,
							got.action, got.loop_forever, got.fade_out_ms,
							got.sound_state);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("[voice_channel_allocator] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unused_code();
		test_fill_and_steal();
		test_fade_stop_and_finish();
		test_pause_resume();
		test_missing_and_stop_all();
		test_random_traffic(RANDOM_ITEMS);
		start <= 1'b0;
		// drain outstanding replies, then watch for strays
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (2 * NCH + 4) @(posedge clk);
		if (error_count == 0)
			$display("[voice_channel_allocator] OK");
		else
			$display("[voice_channel_allocator] ERROR");
		$finish;
	end

endmodule
